// ===== hdl/next_fit_slot_pool_with_lifetime_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef NEXT_FIT_SLOT_POOL_WITH_LIFETIME_UNIT_DEFINES_SVH
`define NEXT_FIT_SLOT_POOL_WITH_LIFETIME_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NFSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/nfsp_pkg.sv =====
package nfsp_pkg;

    typedef enum logic [1:0] {
        CMD_EMIT  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TICK,
        ST_DONE
    } state_t;

    localparam logic [6:0]  POOL_SIZE_RESET = 7'd64;
    localparam logic [31:0] AGE_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] FAIL_MAX        = 32'hFFFF_FFFF;

endpackage

// ===== hdl/nfsp_if.sv =====
// Command channel: one word per command.
interface nfsp_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] start_age;
    logic [30:0]        lifetime;
    logic [30:0]        time_step;

    modport source (output valid, command, start_age, lifetime, time_step, input ready);
    modport sink   (input valid, command, start_age, lifetime, time_step, output ready);
endinterface

// Result channel: one word per command.
interface nfsp_res_if;
    logic        valid;
    logic        ready;
    logic        emit_ok;
    logic [5:0]  slot_index;
    logic [6:0]  retired;
    logic [6:0]  live_count;
    logic [31:0] failure_count;

    modport source (output valid, emit_ok, slot_index, retired, live_count, failure_count,
                    input ready);
    modport sink   (input valid, emit_ok, slot_index, retired, live_count, failure_count,
                    output ready);
endinterface

// Configuration write channel: pool_size register.
interface nfsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] pool_size;

    modport source (output valid, pool_size, input ready);
    modport sink   (input valid, pool_size, output ready);
endinterface

// ===== hdl/next_fit_slot_pool_with_lifetime_unit.sv =====
// Channel   Dir   Word contents
// cfg       in    pool_size (7b)
// cmd       in    command (2b), start_age (s32), lifetime (31b), time_step (31b)
// res       out   emit_ok, slot_index (6b), retired (7b), live_count (7b), failure_count
//
// Per word: emit runs the next-fit scan until it finds a free slot, or fails after visiting
// all size slots (size = effective pool size); tick walks all POOL_DEPTH entries of the
// age/lifetime memory through its one-deep read pipeline; clear and the unused code go
// straight to the result step.
// Reset (rst_n, async, active low) empties the pool and loads pool_size with 64; no
// clearing pass is needed since the memory is only read behind the active flags.
// A stalled result holds in the output register; the next command is taken meanwhile and
// waits in its final step until the register drains.
module next_fit_slot_pool_with_lifetime_unit #(
    parameter int POOL_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    nfsp_cfg_if.sink     cfg,
    nfsp_cmd_if.sink     cmd,
    nfsp_res_if.source   res
);

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int SW = (CW > 7) ? CW : 7;
    localparam int MW = 63;   // {age[31:0], lifetime[30:0]}

    // Sequencer state
    nfsp_pkg::state_t state_reg, state_next;

    // Pool state
    logic [6:0]            pool_size_reg;
    logic [POOL_DEPTH-1:0] active_reg;
    logic [AW-1:0]         cursor_reg;
    logic [CW-1:0]         live_reg;
    logic [31:0]           fail_reg;

    // Working registers for the command in flight
    logic [AW-1:0]         slot_reg;
    logic [CW-1:0]         scan_cnt_reg;
    logic [CW-1:0]         tick_cnt_reg;
    logic                  pipe_vld_reg;
    logic [AW-1:0]         pipe_addr_reg;
    logic signed [31:0]    start_age_reg;
    logic [30:0]           lifetime_reg;
    logic [30:0]           step_reg;
    logic                  ok_reg;
    logic [AW-1:0]         hit_slot_reg;
    logic [CW-1:0]         retired_reg;

    // Age/lifetime store
    logic [MW-1:0]         slot_mem [POOL_DEPTH];
    logic [MW-1:0]         rd_q_reg;

    // Output register
    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic [5:0]            out_slot_reg;
    logic [6:0]            out_retired_reg;
    logic [6:0]            out_live_reg;
    logic [31:0]           out_fail_reg;

    // Control strobes
    logic                  accept;
    logic                  scan_end;
    logic                  scan_hit;
    logic                  scan_miss;
    logic                  tick_issue;
    logic                  tick_write;
    logic                  tick_retire;
    logic                  res_load;

    // Datapath signals
    logic [SW-1:0]         pool_ext;
    logic [CW-1:0]         eff_size;
    logic [AW-1:0]         scan_start;
    logic [CW-1:0]         slot_inc;
    logic [AW-1:0]         slot_wrap;
    logic signed [31:0]    rd_age;
    logic [30:0]           rd_life;
    logic signed [32:0]    age_sum;
    logic [31:0]           new_age;

    // Emit only searches the first pool_size slots, capped at the depth.
    assign pool_ext = SW'(pool_size_reg);
    assign eff_size = (pool_ext > SW'(POOL_DEPTH)) ? CW'(POOL_DEPTH) : CW'(pool_ext);

    // Restart from slot 0 when the cursor fell outside a shrunken pool.
    assign scan_start = (CW'(cursor_reg) < eff_size) ? cursor_reg : '0;

    assign slot_inc  = CW'(slot_reg) + CW'(1);
    assign slot_wrap = (slot_inc < eff_size) ? AW'(slot_inc) : '0;

    // Tick: saturating add of the step, then signed compare against the lifetime.
    assign rd_age  = rd_q_reg[62:31];
    assign rd_life = rd_q_reg[30:0];
    assign age_sum = {rd_age[31], rd_age} + $signed({2'b00, step_reg});
    assign new_age = (age_sum > $signed({1'b0, nfsp_pkg::AGE_MAX}))
                   ? nfsp_pkg::AGE_MAX : age_sum[31:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfsp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.command)
                        nfsp_pkg::CMD_EMIT: state_next = nfsp_pkg::ST_SCAN;
                        nfsp_pkg::CMD_TICK: state_next = nfsp_pkg::ST_TICK;
                        default:            state_next = nfsp_pkg::ST_DONE;
                    endcase
                end
            end
            nfsp_pkg::ST_SCAN:
            begin
                if (scan_hit || scan_miss)
                    state_next = nfsp_pkg::ST_DONE;
            end
            nfsp_pkg::ST_TICK:
            begin
                if (tick_cnt_reg == CW'(POOL_DEPTH) && !pipe_vld_reg)
                    state_next = nfsp_pkg::ST_DONE;
            end
            nfsp_pkg::ST_DONE:
            begin
                if (res_load)
                    state_next = nfsp_pkg::ST_IDLE;
            end
            default: state_next = nfsp_pkg::ST_IDLE;
        endcase
    end

    // Strobes
    always_comb
    begin
        cmd.ready   = (state_reg == nfsp_pkg::ST_IDLE);
        cfg.ready   = 1'b1;
        accept      = cmd.valid && cmd.ready;
        scan_end    = (scan_cnt_reg == eff_size);
        scan_hit    = (state_reg == nfsp_pkg::ST_SCAN) && !scan_end && !active_reg[slot_reg];
        scan_miss   = (state_reg == nfsp_pkg::ST_SCAN) && scan_end;
        tick_issue  = (state_reg == nfsp_pkg::ST_TICK) && (tick_cnt_reg < CW'(POOL_DEPTH));
        tick_write  = pipe_vld_reg && active_reg[pipe_addr_reg];
        tick_retire = tick_write && ($signed(new_age) >= $signed({1'b0, rd_life}));
        res_load    = (state_reg == nfsp_pkg::ST_DONE) && (!out_valid_reg || res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nfsp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pool_size_reg <= nfsp_pkg::POOL_SIZE_RESET;
        else if (cfg.valid && cfg.ready)
            pool_size_reg <= cfg.pool_size;
    end

    // Pool state: flags, cursor, live and failure counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            cursor_reg <= '0;
            live_reg   <= '0;
            fail_reg   <= '0;
        end
        else
        begin
            if (accept && cmd.command == nfsp_pkg::CMD_CLEAR)
            begin
                active_reg <= '0;
                cursor_reg <= '0;
                live_reg   <= '0;
                fail_reg   <= '0;
            end
            if (scan_hit)
            begin
                active_reg[slot_reg] <= 1'b1;
                cursor_reg           <= slot_wrap;
                live_reg             <= live_reg + CW'(1);
            end
            if (scan_miss && fail_reg != nfsp_pkg::FAIL_MAX)
                fail_reg <= fail_reg + 32'd1;
            if (tick_retire)
            begin
                active_reg[pipe_addr_reg] <= 1'b0;
                live_reg                  <= live_reg - CW'(1);
            end
        end
    end

    // Working registers: scan position, memory walk, per-command result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_vld_reg <= 1'b0;
        else
            pipe_vld_reg <= tick_issue;
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg <= AW'(tick_cnt_reg);
        if (accept)
        begin
            slot_reg      <= scan_start;
            scan_cnt_reg  <= '0;
            tick_cnt_reg  <= '0;
            start_age_reg <= cmd.start_age;
            lifetime_reg  <= cmd.lifetime;
            step_reg      <= cmd.time_step;
            ok_reg        <= 1'b0;
            hit_slot_reg  <= '0;
            retired_reg   <= '0;
        end
        else
        begin
            // Advance the scan around the pool; hold on a hit.
            if (state_reg == nfsp_pkg::ST_SCAN && !scan_end)
            begin
                if (scan_hit)
                begin
                    ok_reg       <= 1'b1;
                    hit_slot_reg <= slot_reg;
                    scan_cnt_reg <= eff_size;
                end
                else
                begin
                    slot_reg     <= slot_wrap;
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
            end
            if (tick_issue)
                tick_cnt_reg <= tick_cnt_reg + CW'(1);
            if (tick_retire)
                retired_reg <= retired_reg + CW'(1);
        end
    end

    // Age/lifetime memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (scan_hit)
            slot_mem[slot_reg] <= {start_age_reg, lifetime_reg};
        else if (tick_write)
            slot_mem[pipe_addr_reg] <= {new_age, rd_life};
        if (tick_issue)
            rd_q_reg <= slot_mem[AW'(tick_cnt_reg)];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_ok_reg      <= ok_reg;
            out_slot_reg    <= 6'(hit_slot_reg);
            out_retired_reg <= 7'(retired_reg);
            out_live_reg    <= 7'(live_reg);
            out_fail_reg    <= fail_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.emit_ok       = out_ok_reg;
    assign res.slot_index    = out_slot_reg;
    assign res.retired       = out_retired_reg;
    assign res.live_count    = out_live_reg;
    assign res.failure_count = out_fail_reg;

endmodule

// ===== hdl/nfsp_checker.sv =====
`include "next_fit_slot_pool_with_lifetime_unit_defines.svh"

module nfsp_checker #(
    parameter int POOL_DEPTH = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        emit_ok,
    input logic [5:0]  slot_index,
    input logic [6:0]  retired,
    input logic [6:0]  live_count,
    input logic [31:0] failure_count
);

    // One command at a time: the port drops ready after taking a word.
    `NFSP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "ready held high after accept")

    // A stalled result holds.
    `NFSP_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(failure_count) && $stable(live_count), "stalled result changed")

    // An emit result retires nothing.
    `NFSP_ASSERT_NOW(a_emit_no_retire, clk, rst_n, res_valid && emit_ok, retired == 7'd0, "emit result reports retired slots")

    // Anything but a successful emit reports slot 0.
    `NFSP_ASSERT_NOW(a_slot_zero, clk, rst_n, res_valid && !emit_ok, slot_index == 6'd0, "slot index set without emit")

    // Live count never exceeds the pool depth.
    `NFSP_ASSERT_NOW(a_live_bound, clk, rst_n, res_valid, (POOL_DEPTH > 127) || (live_count <= 7'(POOL_DEPTH)), "live count above depth")

endmodule

bind next_fit_slot_pool_with_lifetime_unit nfsp_checker #(
    .POOL_DEPTH (POOL_DEPTH)
) u_nfsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .emit_ok       (res.emit_ok),
    .slot_index    (res.slot_index),
    .retired       (res.retired),
    .live_count    (res.live_count),
    .failure_count (res.failure_count)
);
